// File: rtl/ssm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

   localparam logic [1:0] FUNC_ELEM_A = 2'd0;
   localparam logic [1:0] FUNC_ELEM_B = 2'd1;
   localparam logic [1:0] FUNC_END_A  = 2'd2;
   localparam logic [1:0] FUNC_END_B  = 2'd3;

   localparam int unsigned DATA_W = 32;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
      logic              has_value;
      logic              last;
      logic              overflow;
   } ssm_result_type;

endpackage

`default_nettype wire

// File: rtl/sorted_stream_merge.sv
// Two-way merge of ascending signed 32-bit sequences A and B that arrive interleaved
// on one request channel (func: element of A, element of B, end of A, end of B). Items
// of whichever sequence is ahead wait in a circular buffer of BUFFER_DEPTH entries held
// in a synchronous RAM; an arriving item of the other sequence releases every buffered
// item that precedes it, ties going to B. When both sequences have ended the buffer is
// flushed and the final result carries last (a bare end result with has_value low if
// nothing remains), and the block clears for the next pair. An element that finds the
// buffer full is dropped and reported by one result with overflow set. Each request
// passes through an accept state, which issues the RAM read of the buffer head, and a
// decision state that compares against the registered head. Each released or flushed
// result waits on the next head read from the single RAM read port, and backpressure on
// the response channel stalls it. Results leave through an output register, so a new
// request is taken while a result waits. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_stream_merge #(
   parameter int unsigned BUFFER_DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [1:0]                 req_func,
   input  wire logic signed [ssm_pkg::DATA_W-1:0] req_value,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic signed [ssm_pkg::DATA_W-1:0] rsp_merged_value,
   output      logic                       rsp_has_value,
   output      logic                       rsp_last,
   output      logic                       rsp_overflow
);
   import ssm_pkg::*;

   localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH + 1);

   logic              slot_free;
   ssm_result_type    put;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_has_value_ff;
   logic              rsp_last_ff;
   logic              rsp_overflow_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   ssm_ctrl #(
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_value (req_value),
      .slot_free (slot_free),
      .put       (put),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   ssm_buffer #(
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (put.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put.valid) begin
         rsp_value_ff     <= put.value;
         rsp_has_value_ff <= put.has_value;
         rsp_last_ff      <= put.last;
         rsp_overflow_ff  <= put.overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = $signed(rsp_value_ff);
   assign rsp_has_value    = rsp_has_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

`default_nettype wire

// File: rtl/ssm_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

module ssm_buffer #(
   parameter int unsigned DEPTH  = 32,
   parameter int unsigned ADDR_W = 5
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [ssm_pkg::DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output      logic [ssm_pkg::DATA_W-1:0] rd_data
);
   import ssm_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/ssm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ssm_ctrl #(
   parameter int unsigned DEPTH  = 32,
   parameter int unsigned ADDR_W = 5,
   parameter int unsigned CNT_W  = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [1:0]                 req_func,
   input  wire logic [ssm_pkg::DATA_W-1:0] req_value,
   input  wire logic                       slot_free,
   output      ssm_pkg::ssm_result_type    put,
   output      logic                       wr_en,
   output      logic [ADDR_W-1:0]          wr_addr,
   output      logic [ssm_pkg::DATA_W-1:0] wr_data,
   output      logic [ADDR_W-1:0]          rd_addr,
   input  wire logic [ssm_pkg::DATA_W-1:0] rd_data
);
   import ssm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WORK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam int unsigned SUM_W = CNT_W + 1;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              side_ff, side_in;
   logic              ended_a_ff, ended_a_in;
   logic              ended_b_ff, ended_b_in;
   logic              final_ff, final_in;
   logic [1:0]        func_ff;
   logic [DATA_W-1:0] value_ff;

   logic              is_end;
   logic              item_side;
   logic              own_ended;
   logic              other_ended;
   logic              go;
   logic              pop;
   logic              clear;
   logic              count_last;
   logic              count_zero;
   logic              emit_req;
   logic [ADDR_W-1:0] head_inc;
   logic [SUM_W-1:0]  wr_sum;
   ssm_result_type    res;

   assign is_end      = (func_ff == FUNC_END_A) || (func_ff == FUNC_END_B);
   assign item_side   = (func_ff == FUNC_ELEM_B) || (func_ff == FUNC_END_B);
   assign own_ended   = item_side ? ended_b_ff : ended_a_ff;
   assign other_ended = item_side ? ended_a_ff : ended_b_ff;
   assign count_last  = (count_ff == CNT_W'(1));
   assign count_zero  = (count_ff == '0);
   assign go = side_ff ? ($signed(rd_data) <= $signed(value_ff))
                       : ($signed(rd_data) <  $signed(value_ff));

   assign head_inc = (head_ff == ADDR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign wr_sum   = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_addr  = (wr_sum >= SUM_W'(DEPTH)) ? ADDR_W'(wr_sum - SUM_W'(DEPTH))
                                               : ADDR_W'(wr_sum);
   assign wr_data  = value_ff;
   assign rd_addr  = pop ? head_inc : head_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      side_in    = side_ff;
      ended_a_in = ended_a_ff;
      ended_b_in = ended_b_ff;
      final_in   = final_ff;
      pop        = 1'b0;
      clear      = 1'b0;
      wr_en      = 1'b0;
      emit_req   = 1'b0;
      res        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (own_ended) begin
               state_in = ST_IDLE;
            end else if (!is_end) begin
               if (!count_zero && (side_ff != item_side)) begin
                  emit_req      = 1'b1;
                  res.has_value = 1'b1;
                  if (go) begin
                     res.value = rd_data;
                     pop       = slot_free;
                  end else begin
                     res.value = value_ff;
                     if (slot_free) begin
                        state_in = ST_IDLE;
                     end
                  end
               end else if (other_ended) begin
                  emit_req      = 1'b1;
                  res.has_value = 1'b1;
                  res.value     = value_ff;
                  if (slot_free) begin
                     state_in = ST_IDLE;
                  end
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  emit_req     = 1'b1;
                  res.overflow = 1'b1;
                  if (slot_free) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  side_in  = item_side;
                  state_in = ST_IDLE;
               end
            end else begin
               if (!other_ended) begin
                  if (item_side) begin
                     ended_b_in = 1'b1;
                  end else begin
                     ended_a_in = 1'b1;
                  end
                  if (!count_zero && (side_ff != item_side)) begin
                     final_in = 1'b0;
                     state_in = ST_DRAIN;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (count_zero) begin
                  emit_req = 1'b1;
                  res.last = 1'b1;
                  if (slot_free) begin
                     clear    = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  final_in = 1'b1;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            emit_req      = 1'b1;
            res.has_value = 1'b1;
            res.value     = rd_data;
            res.last      = final_ff && count_last;
            if (slot_free) begin
               pop = 1'b1;
               if (count_last) begin
                  state_in = ST_IDLE;
                  clear    = final_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (pop) begin
         head_in  = head_inc;
         count_in = count_ff - 1'b1;
      end
      if (clear) begin
         head_in    = '0;
         count_in   = '0;
         side_in    = 1'b0;
         ended_a_in = 1'b0;
         ended_b_in = 1'b0;
      end
   end

   always_comb begin
      put       = res;
      put.valid = emit_req && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         side_ff    <= 1'b0;
         ended_a_ff <= 1'b0;
         ended_b_ff <= 1'b0;
         final_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         side_ff    <= side_in;
         ended_a_ff <= ended_a_in;
         ended_b_ff <= ended_b_in;
         final_ff   <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("buffer count exceeds depth");

   a_put_slot: assert property (@(posedge clock) disable iff (reset)
      put.valid |-> slot_free)
      else $error("transfer issued into a busy output register");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> count_ff != '0)
      else $error("drain with empty buffer");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      put.valid && put.last |=> (count_ff == '0) && !ended_a_ff && !ended_b_ff
                                && (state_ff == ST_IDLE))
      else $error("state not cleared after final result");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CNT_W'(DEPTH)) && (state_ff == ST_WORK))
      else $error("buffer write without room");

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import ssm_pkg::*;

   localparam int unsigned BUF_DEPTH = 32;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_OFF_CYCLES = 250;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct {
      word_type value;
      logic     has_value;
      logic     last;
      logic     overflow;
   } merge_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_ELEM_A;
   word_type   req_value = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   word_type   rsp_merged_value;
   logic       rsp_has_value;
   logic       rsp_last;
   logic       rsp_overflow;

   merge_result_type merge_due_q[$];
   word_type         held_vals[BUF_DEPTH];
   int unsigned      held_head;
   int unsigned      held_count;
   bit               held_side;
   bit               a_done;
   bit               b_done;

   bit          idle_on = 1'b1;
   int unsigned hold_request = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned items_taken = 0;
   int unsigned results_seen = 0;
   int unsigned overflow_seen = 0;
   int unsigned last_seen = 0;

   sorted_stream_merge #(
      .BUFFER_DEPTH(BUF_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_merged_value(rsp_merged_value),
      .rsp_has_value   (rsp_has_value),
      .rsp_last        (rsp_last),
      .rsp_overflow    (rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void push_merged(word_type v, bit hv, bit lst, bit ovf);
      merge_result_type r;
      r.value = hv ? v : '0;
      r.has_value = hv;
      r.last = lst;
      r.overflow = ovf;
      merge_due_q.push_back(r);
   endfunction

   function automatic word_type pop_held();
      word_type v;
      v = held_vals[held_head];
      held_head = (held_head + 1) % BUF_DEPTH;
      held_count--;
      return v;
   endfunction

   function automatic void clear_merge_state();
      held_head = 0;
      held_count = 0;
      held_side = 1'b0;
      a_done = 1'b0;
      b_done = 1'b0;
   endfunction

   // returns 0 when the item is ignored
   function automatic bit predict_merge(logic [1:0] f, word_type v);
      bit       side;
      bit       own_done;
      bit       other_done;
      bit       go;
      word_type h;
      side = f[0];
      own_done = side ? b_done : a_done;
      other_done = side ? a_done : b_done;
      if (own_done)
         return 1'b0;
      if (f == FUNC_ELEM_A || f == FUNC_ELEM_B) begin
         if (held_count != 0 && held_side != side) begin
            while (held_count != 0) begin
               h = held_vals[held_head];
               go = held_side ? (h <= v) : (h < v);
               if (!go)
                  break;
               push_merged(pop_held(), 1'b1, 1'b0, 1'b0);
            end
            if (held_count != 0) begin
               push_merged(v, 1'b1, 1'b0, 1'b0);
               return 1'b1;
            end
         end
         if (other_done) begin
            push_merged(v, 1'b1, 1'b0, 1'b0);
            return 1'b1;
         end
         if (held_count >= BUF_DEPTH) begin
            push_merged('0, 1'b0, 1'b0, 1'b1);
            return 1'b1;
         end
         held_side = side;
         held_vals[(held_head + held_count) % BUF_DEPTH] = v;
         held_count++;
         return 1'b1;
      end
      if (side)
         b_done = 1'b1;
      else
         a_done = 1'b1;
      if (!other_done) begin
         if (held_side != side)
            while (held_count != 0)
               push_merged(pop_held(), 1'b1, 1'b0, 1'b0);
         return 1'b1;
      end
      if (held_count == 0) begin
         push_merged('0, 1'b0, 1'b1, 1'b0);
      end else begin
         while (held_count != 0) begin
            h = pop_held();
            push_merged(h, 1'b1, held_count == 0, 1'b0);
         end
      end
      clear_merge_state();
      return 1'b1;
   endfunction

   task automatic send_item(input logic [1:0] f, input word_type v);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      if (predict_merge(f, v))
         items_taken++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (merge_due_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic fill_run(ref word_type run[$], input int len, input bit narrow);
      longint acc;
      run.delete();
      if (narrow)
         acc = longint'(int'($urandom_range(0, 20)) - 10);
      else if ($urandom_range(0, 1) == 0)
         acc = longint'($signed($urandom()));
      else
         acc = longint'($signed($urandom()) >>> 1) - 64'sd1073741824;
      for (int i = 0; i < len; i++) begin
         run.push_back(word_type'(acc));
         if (narrow)
            acc += $urandom_range(0, 2);
         else if ($urandom_range(0, 3) == 0)
            acc += 0;
         else
            acc += $urandom_range(1, 1 << 24);
         if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
      end
   endtask

   task automatic send_pair(input int len_a, input int len_b, input bit noisy);
      word_type seq_a[$];
      word_type seq_b[$];
      int       ia;
      int       ib;
      bit       a_sent;
      bit       b_sent;
      bit       pick_b;
      bit       narrow;
      word_type v;
      narrow = ($urandom_range(0, 2) == 0);
      fill_run(seq_a, len_a, narrow);
      fill_run(seq_b, len_b, narrow);
      ia = 0;
      ib = 0;
      a_sent = 1'b0;
      b_sent = 1'b0;
      while (!(a_sent && b_sent)) begin
         if (noisy && $urandom_range(0, 19) == 0) begin
            send_item(2'($urandom_range(0, 3)), $signed($urandom()));
            continue;
         end
         pick_b = a_sent ? 1'b1 : b_sent ? 1'b0 : 1'($urandom_range(0, 1));
         if (!pick_b) begin
            if (ia < seq_a.size()) begin
               v = seq_a[ia++];
               if (noisy && $urandom_range(0, 24) == 0)
                  v = $signed($urandom());
               send_item(FUNC_ELEM_A, v);
            end else begin
               send_item(FUNC_END_A, $signed($urandom()));
               a_sent = 1'b1;
            end
         end else begin
            if (ib < seq_b.size()) begin
               v = seq_b[ib++];
               if (noisy && $urandom_range(0, 24) == 0)
                  v = $signed($urandom());
               send_item(FUNC_ELEM_B, v);
            end else begin
               send_item(FUNC_END_B, $signed($urandom()));
               b_sent = 1'b1;
            end
         end
      end
   endtask

   task automatic test_directed();
      send_item(FUNC_END_A, 32'sd0);
      send_item(FUNC_END_B, -32'sd1);
      send_item(FUNC_ELEM_A, 32'sh8000_0000);
      send_item(FUNC_ELEM_A, -32'sd1);
      send_item(FUNC_ELEM_B, 32'sh8000_0000);
      send_item(FUNC_ELEM_B, 32'sd0);
      send_item(FUNC_END_B, 32'sd0);
      send_item(FUNC_ELEM_B, 32'sd77);
      send_item(FUNC_END_B, 32'sd0);
      send_item(FUNC_ELEM_A, 32'sd0);
      send_item(FUNC_ELEM_A, 32'sh7fff_ffff);
      send_item(FUNC_END_A, 32'sh7fff_ffff);
      send_item(FUNC_ELEM_B, 32'sd5);
      send_item(FUNC_ELEM_B, 32'sd7);
      send_item(FUNC_ELEM_A, 32'sd7);
      send_item(FUNC_END_A, 32'sd0);
      send_item(FUNC_END_B, 32'sd0);
      send_item(FUNC_ELEM_A, 32'sd3);
      send_item(FUNC_ELEM_A, 32'sd9);
      send_item(FUNC_END_B, 32'sd0);
      send_item(FUNC_END_A, 32'sd0);
      send_item(FUNC_ELEM_B, 32'sh7fff_ffff);
      send_item(FUNC_ELEM_A, 32'sh7fff_ffff);
      send_item(FUNC_ELEM_B, 32'sh7fff_ffff);
      send_item(FUNC_END_A, 32'sd0);
      send_item(FUNC_END_B, 32'sd0);
      drain_results();
   endtask

   task automatic test_buffer_full();
      for (int i = 0; i < BUF_DEPTH + 2; i++)
         send_item(FUNC_ELEM_A, word_type'(i * 3 - 40));
      send_item(FUNC_ELEM_B, 32'sd1000);
      send_item(FUNC_ELEM_B, 32'sd1001);
      send_item(FUNC_END_A, 32'sd0);
      send_item(FUNC_END_B, 32'sd0);
      drain_results();
   endtask

   task automatic test_output_hold_off();
      hold_request = HOLD_OFF_CYCLES;
      while (rsp_ready) @(posedge clock);
      send_item(FUNC_END_A, 32'sd0);
      for (int i = 0; i < 40; i++)
         send_item(FUNC_ELEM_B, $signed($urandom()));
      send_item(FUNC_END_B, 32'sd0);
      drain_results();
   endtask

   task automatic test_random_pairs(input int unsigned target, input bit noisy);
      int unsigned start;
      int          la;
      int          lb;
      start = items_taken;
      while (items_taken - start < target) begin
         if ($urandom_range(0, 15) == 0) begin
            la = $urandom_range(28, 40);
            lb = $urandom_range(0, 6);
            if ($urandom_range(0, 1) == 0) begin
               lb = la;
               la = $urandom_range(0, 6);
            end
         end else begin
            la = $urandom_range(0, 10);
            lb = $urandom_range(0, 10);
         end
         send_pair(la, lb, noisy);
      end
      drain_results();
   endtask

   initial begin : result_sink
      int unsigned n;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : result_check
      merge_result_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_overflow === 1'b1)
               overflow_seen++;
            if (rsp_last === 1'b1)
               last_seen++;
            if (merge_due_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("[%0t] unexpected result: value %0d has_value %b last %b ovf %b",
                           $time, rsp_merged_value, rsp_has_value, rsp_last, rsp_overflow);
               mismatch_count++;
            end else begin
               e = merge_due_q.pop_front();
               if (rsp_merged_value !== e.value || rsp_has_value !== e.has_value ||
                   rsp_last !== e.last || rsp_overflow !== e.overflow) begin
                  if (mismatch_count < 10) begin
                     $display("[%0t] mismatch: expected value %0d has_value %b last %b ovf %b",
                              $time, e.value, e.has_value, e.last, e.overflow);
                     $display("[%0t]           got value %0d has_value %b last %b ovf %b",
                              $time, rsp_merged_value, rsp_has_value, rsp_last,
                              rsp_overflow);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, merge_due_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      clear_merge_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_buffer_full();
      test_output_hold_off();
      test_random_pairs(250, 1'b1);
      idle_on = 1'b0;
      test_random_pairs(60, 1'b0);
      while (merge_due_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("merge run: %0d items taken, %0d results checked in %0d cycles",
               items_taken, results_seen, cycle_count);
      $display("sequence ends seen: %0d, dropped-element reports: %0d, mismatches: %0d",
               last_seen, overflow_seen, mismatch_count);
      if (mismatch_count == 0 && merge_due_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
